@@ hw/rtl/alarm_clock_controller_defines.svh @@
// Assertion macros used by alarm_clock_controller.sv.
`ifndef ALARM_CLOCK_CONTROLLER_DEFINES_SVH
`define ALARM_CLOCK_CONTROLLER_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define ACC_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define ACC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/acc_pkg.sv @@
`timescale 1ns / 1ps

package acc_pkg;

   localparam logic [1:0] CMD_TICK = 2'd0;
   localparam logic [1:0] CMD_KEY  = 2'd1;
   localparam logic [1:0] CMD_TEMP = 2'd2;

   localparam logic [1:0] MODE_RUN       = 2'd0;
   localparam logic [1:0] MODE_SET_TIME  = 2'd1;
   localparam logic [1:0] MODE_SET_ALARM = 2'd2;

   localparam logic [1:0] FIELD_HOUR   = 2'd0;
   localparam logic [1:0] FIELD_MINUTE = 2'd1;
   localparam logic [1:0] FIELD_SECOND = 2'd2;

   localparam logic [1:0] STEP_LAST = 2'd3;

   localparam logic [3:0] KEY_SET_TIME  = 4'd8;
   localparam logic [3:0] KEY_UP        = 4'd9;
   localparam logic [3:0] KEY_SET_ALARM = 4'd12;
   localparam logic [3:0] KEY_DOWN      = 4'd13;

   localparam logic [3:0] CODE_BLANK = 4'd10;
   localparam logic [3:0] CODE_DASH  = 4'd11;
   localparam logic [3:0] CODE_C     = 4'd12;

   localparam logic [5:0] HOURS_PER_DAY = 6'd24;
   localparam logic [5:0] MINUTES_PER_HOUR = 6'd60;
   localparam logic [6:0] TEMP_MAX = 7'd99;

   localparam logic [4:0] RESET_HOUR   = 5'd23;
   localparam logic [5:0] RESET_MINUTE = 6'd59;
   localparam logic [5:0] RESET_SECOND = 6'd50;

   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
   } hms_type;

   typedef logic [7:0][3:0] digits_type;

   function automatic logic [5:0] wrap_up(input logic [5:0] v, input logic [5:0] lim);
      logic [6:0] sum;
      sum = {1'b0, v} + 7'd1;
      return (sum >= {1'b0, lim}) ? 6'd0 : sum[5:0];
   endfunction

   function automatic logic [5:0] wrap_down(input logic [5:0] v, input logic [5:0] lim);
      return (v == 6'd0 || v >= lim) ? lim - 6'd1 : v - 6'd1;
   endfunction

   // Tens digit by multiplying with the reciprocal of ten; exact for values up to 99.
   function automatic logic [3:0] dec_tens(input logic [6:0] v);
      logic [14:0] prod;
      prod = {8'd0, v} * 15'd205;
      return prod[14:11];
   endfunction

   function automatic logic [3:0] dec_ones(input logic [6:0] v);
      logic [3:0] tens;
      logic [6:0] rest;
      tens = dec_tens(v);
      rest = v - ({tens, 3'b000} + {2'b00, tens, 1'b0});
      return rest[3:0];
   endfunction

endpackage

@@ hw/rtl/acc_fmt.sv @@
`timescale 1ns / 1ps

module acc_fmt (
   input  acc_pkg::hms_type    time_val,
   output acc_pkg::digits_type digits
);
   import acc_pkg::*;

   logic [6:0] hour_ext;
   logic [6:0] minute_ext;
   logic [6:0] second_ext;

   assign hour_ext   = {2'b00, time_val.hour};
   assign minute_ext = {1'b0, time_val.minute};
   assign second_ext = {1'b0, time_val.second};

   assign digits[0] = dec_tens(hour_ext);
   assign digits[1] = dec_ones(hour_ext);
   assign digits[2] = CODE_DASH;
   assign digits[3] = dec_tens(minute_ext);
   assign digits[4] = dec_ones(minute_ext);
   assign digits[5] = CODE_DASH;
   assign digits[6] = dec_tens(second_ext);
   assign digits[7] = dec_ones(second_ext);

endmodule

@@ hw/rtl/alarm_clock_controller.sv @@
// An item is held in the input register until processed; its result is then registered.
// Throughput: one item per cycle unless rsp_stall holds it; one state update per item.
// The input register stalls only when it is full and the result register is stalled.
// Synchronous active-high reset sets the time to 23:59:50, the alarm to 00:00:00,
// run mode, an all-blank display and empty input and result registers.
`timescale 1ns / 1ps
`include "alarm_clock_controller_defines.svh"

module alarm_clock_controller (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_cmd,
   input  logic [3:0] req_key_code,
   input  logic [6:0] req_temp_value,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [3:0] rsp_digit0,
   output logic [3:0] rsp_digit1,
   output logic [3:0] rsp_digit2,
   output logic [3:0] rsp_digit3,
   output logic [3:0] rsp_digit4,
   output logic [3:0] rsp_digit5,
   output logic [3:0] rsp_digit6,
   output logic [3:0] rsp_digit7,
   output logic       rsp_alarm_active
);
   import acc_pkg::*;

   logic       in_valid_ff;
   logic [1:0] cmd_ff;
   logic [3:0] key_ff;
   logic [6:0] temp_value_ff;
   logic       rsp_valid_ff;
   logic       alarm_ff;
   logic       alarm_in;

   hms_type    cur_ff, cur_in;
   hms_type    alm_ff, alm_in;
   logic [1:0] mode_ff, mode_in;
   logic [1:0] field_ff, field_in;
   logic [1:0] step_ff, step_in;
   logic       show_temp_ff, show_temp_in;
   logic       hold_ff, hold_in;
   logic       blink_ff, blink_in;
   logic [6:0] temp_ff, temp_in;
   digits_type buffer_ff, buffer_in;

   logic       advance;
   logic       fire;
   logic       blink_do;
   hms_type    adj_val;
   hms_type    fmt_src;
   digits_type fmt_digits;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   always_comb begin
      cur_in       = cur_ff;
      alm_in       = alm_ff;
      mode_in      = mode_ff;
      field_in     = field_ff;
      step_in      = step_ff;
      show_temp_in = show_temp_ff;
      hold_in      = hold_ff;
      blink_in     = blink_ff;
      temp_in      = temp_ff;
      blink_do     = 1'b0;
      adj_val      = (mode_ff == MODE_SET_ALARM) ? alm_ff : cur_ff;
      case (cmd_ff)
         CMD_TICK: begin
            if (mode_ff == MODE_RUN) begin
               cur_in.second = wrap_up(cur_ff.second, MINUTES_PER_HOUR);
               if (cur_in.second == 6'd0) begin
                  cur_in.minute = wrap_up(cur_ff.minute, MINUTES_PER_HOUR);
                  if (cur_in.minute == 6'd0) begin
                     cur_in.hour = 5'(wrap_up({1'b0, cur_ff.hour}, HOURS_PER_DAY));
                  end
               end
               hold_in = 1'b0;
            end else if (field_ff != STEP_LAST) begin
               blink_do = 1'b1;
               blink_in = !blink_ff;
            end
         end
         CMD_KEY: begin
            if (key_ff inside {KEY_SET_TIME, KEY_SET_ALARM}) begin
               if (step_ff != STEP_LAST) begin
                  mode_in  = (key_ff == KEY_SET_TIME) ? MODE_SET_TIME : MODE_SET_ALARM;
                  field_in = step_ff;
                  step_in  = step_ff + 2'd1;
               end else begin
                  mode_in  = MODE_RUN;
                  field_in = FIELD_HOUR;
                  step_in  = 2'd0;
               end
               hold_in = 1'b1;
            end else if (key_ff inside {KEY_UP, KEY_DOWN}) begin
               hold_in = 1'b1;
               if (mode_ff == MODE_RUN) begin
                  if (key_ff == KEY_DOWN) begin
                     show_temp_in = !show_temp_ff;
                  end
               end else begin
                  case (field_ff)
                     FIELD_HOUR: begin
                        adj_val.hour = (key_ff == KEY_UP)
                           ? 5'(wrap_up({1'b0, adj_val.hour}, HOURS_PER_DAY))
                           : 5'(wrap_down({1'b0, adj_val.hour}, HOURS_PER_DAY));
                     end
                     FIELD_MINUTE: begin
                        adj_val.minute = (key_ff == KEY_UP)
                           ? wrap_up(adj_val.minute, MINUTES_PER_HOUR)
                           : wrap_down(adj_val.minute, MINUTES_PER_HOUR);
                     end
                     FIELD_SECOND: begin
                        adj_val.second = (key_ff == KEY_UP)
                           ? wrap_up(adj_val.second, MINUTES_PER_HOUR)
                           : wrap_down(adj_val.second, MINUTES_PER_HOUR);
                     end
                     default: begin
                     end
                  endcase
                  if (mode_ff == MODE_SET_ALARM) begin
                     alm_in = adj_val;
                  end else if (mode_ff == MODE_SET_TIME) begin
                     cur_in = adj_val;
                  end
               end
            end
         end
         CMD_TEMP: begin
            temp_in = (temp_value_ff > TEMP_MAX) ? TEMP_MAX : temp_value_ff;
         end
         default: begin
         end
      endcase
   end

   assign fmt_src = (mode_in == MODE_RUN || mode_ff != MODE_SET_ALARM) ? cur_in : alm_in;

   acc_fmt u_fmt (
      .time_val (fmt_src),
      .digits   (fmt_digits)
   );

   always_comb begin
      buffer_in = buffer_ff;
      if (mode_in == MODE_RUN) begin
         if (show_temp_in) begin
            buffer_in    = {8{CODE_BLANK}};
            buffer_in[5] = dec_tens(temp_in);
            buffer_in[6] = dec_ones(temp_in);
            buffer_in[7] = CODE_C;
         end else begin
            buffer_in = fmt_digits;
         end
      end else if (blink_do) begin
         buffer_in = fmt_digits;
         if (!blink_ff) begin
            case (field_ff)
               FIELD_HOUR: begin
                  buffer_in[0] = CODE_BLANK;
                  buffer_in[1] = CODE_BLANK;
               end
               FIELD_MINUTE: begin
                  buffer_in[3] = CODE_BLANK;
                  buffer_in[4] = CODE_BLANK;
               end
               FIELD_SECOND: begin
                  buffer_in[6] = CODE_BLANK;
                  buffer_in[7] = CODE_BLANK;
               end
               default: begin
               end
            endcase
         end
      end
   end

   assign alarm_in = (cur_in == alm_in) && !hold_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         cmd_ff        <= req_cmd;
         key_ff        <= req_key_code;
         temp_value_ff <= req_temp_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff       <= '{hour: RESET_HOUR, minute: RESET_MINUTE, second: RESET_SECOND};
         alm_ff       <= '0;
         mode_ff      <= MODE_RUN;
         field_ff     <= FIELD_HOUR;
         step_ff      <= 2'd0;
         show_temp_ff <= 1'b0;
         hold_ff      <= 1'b0;
         blink_ff     <= 1'b0;
         temp_ff      <= 7'd0;
         buffer_ff    <= {8{CODE_BLANK}};
         alarm_ff     <= 1'b0;
      end else if (fire) begin
         cur_ff       <= cur_in;
         alm_ff       <= alm_in;
         mode_ff      <= mode_in;
         field_ff     <= field_in;
         step_ff      <= step_in;
         show_temp_ff <= show_temp_in;
         hold_ff      <= hold_in;
         blink_ff     <= blink_in;
         temp_ff      <= temp_in;
         buffer_ff    <= buffer_in;
         alarm_ff     <= alarm_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_digit0       = buffer_ff[0];
   assign rsp_digit1       = buffer_ff[1];
   assign rsp_digit2       = buffer_ff[2];
   assign rsp_digit3       = buffer_ff[3];
   assign rsp_digit4       = buffer_ff[4];
   assign rsp_digit5       = buffer_ff[5];
   assign rsp_digit6       = buffer_ff[6];
   assign rsp_digit7       = buffer_ff[7];
   assign rsp_alarm_active = alarm_ff;

   `ACC_ASSERT_SAME(a_step_mode, 1'b1, (step_ff == 2'd0) == (mode_ff == MODE_RUN), "press counter and mode disagree")
   `ACC_ASSERT_NEXT(a_fire_result, fire, rsp_valid_ff, "processed item produced no result")
   `ACC_ASSERT_SAME(a_run_dash, rsp_valid_ff && mode_ff == MODE_RUN && !show_temp_ff, buffer_ff[2] == CODE_DASH && buffer_ff[5] == CODE_DASH, "time view lacks separators")

endmodule
